@@ rtl/core/dlrq_pkg.sv @@
// Shared types, constants and helpers for the deadline-ordered release queue.
// Depends on nothing; imported by the core.
package dlrq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RUN     = 32;

    localparam logic [1:0] FUNC_ENQ    = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_PURGE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic RK_RELEASE = 1'b0;
    localparam logic RK_DROP    = 1'b1;

    typedef struct packed {
        logic [31:0] deadline;
        logic [9:0]  kind;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [31:0] facing;
        logic [15:0] flags;
        logic [3:0]  callback;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_REL_RD,
        ST_REL_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT_WAIT
    } state_t;

    // Ring address of logical slot off past head.
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/dlrq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/deadline_ordered_release_queue_core.sv @@
// Top level of the deadline-ordered release queue: control FSM around one entry RAM.
// Depends on dlrq_pkg and dlrq_ram.
//
// Takes one transaction at a time. An enqueue with zero delay, or one that finds the
// queue full, presents its own payload in the cycle after acceptance. A stored enqueue
// walks back from the tail, reading the entry before each slot and moving it up one
// slot until it finds the insert point or reaches the head, then writes the new entry.
// A tick advances time, scans from the head for due entries, reading and checking each
// one, then releases each with a RAM read plus the output handshake. Purge empties the
// queue by zeroing the entry count. No clearing pass.
module deadline_ordered_release_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] delay_ticks,
    input  logic [9:0]  item_kind,
    input  logic [63:0] pos_x,
    input  logic [63:0] pos_y,
    input  logic [63:0] pos_z,
    input  logic [31:0] facing,
    input  logic [15:0] create_flags,
    input  logic [3:0]  callback_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [9:0]  out_kind,
    output logic [63:0] out_x,
    output logic [63:0] out_y,
    output logic [63:0] out_z,
    output logic [31:0] out_facing,
    output logic [15:0] out_flags,
    output logic [3:0]  out_callback,
    output logic        last_of_run
);
    import dlrq_pkg::*;

    state_t           state_reg, state_next;
    logic [31:0]      now_reg, now_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      delay_reg, delay_next;
    entry_t           req_reg, req_next;
    entry_t           out_reg, out_next;
    logic             rk_reg, rk_next;
    logic             last_reg, last_next;
    logic             pop_reg, pop_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;
    logic             accept;
    logic [31:0]      key;
    logic [31:0]      age;
    logic             ins_here;
    logic             due;
    entry_t           in_entry;

    dlrq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign key      = ram_rdata.deadline - now_reg;
    assign age      = now_reg - ram_rdata.deadline;
    assign ins_here = $signed(key) <= $signed({16'd0, delay_reg});
    assign due      = !age[31];

    always_comb
    begin
        in_entry.deadline = now_reg + {16'd0, delay_ticks};
        in_entry.kind     = item_kind;
        in_entry.x        = pos_x;
        in_entry.y        = pos_y;
        in_entry.z        = pos_z;
        in_entry.facing   = facing;
        in_entry.flags    = create_flags;
        in_entry.callback = callback_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            cnt_reg   <= '0;
            head_reg  <= '0;
            idx_reg   <= '0;
            pop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            pop_reg   <= pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg <= delay_next;
        req_reg   <= req_next;
        out_reg   <= out_next;
        rk_reg    <= rk_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        now_next   = now_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        delay_next = delay_reg;
        req_next   = req_reg;
        out_next   = out_reg;
        rk_next    = rk_reg;
        last_next  = last_reg;
        pop_next   = pop_reg;
        ram_we     = 1'b0;
        ram_waddr  = ring_addr(head_reg, idx_reg);
        ram_wdata  = req_reg;
        ram_raddr  = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_ENQ:
                        begin
                            if (delay_ticks == 16'd0 || cnt_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_next   = in_entry;
                                rk_next    = (delay_ticks == 16'd0) ? RK_RELEASE : RK_DROP;
                                last_next  = 1'b1;
                                pop_next   = 1'b0;
                                state_next = ST_OUT_WAIT;
                            end
                            else
                            begin
                                req_next   = in_entry;
                                delay_next = delay_ticks;
                                idx_next   = cnt_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        FUNC_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            idx_next   = '0;
                            state_next = ST_REL_RD;
                        end
                        FUNC_PURGE:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = head_reg;
                    ram_wdata  = req_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = ring_addr(head_reg, idx_reg - CNT_W'(1));
                    state_next = ST_INS_CHK;
                end
            end

            ST_INS_CHK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ring_addr(head_reg, idx_reg);
                if (ins_here)
                begin
                    ram_wdata  = req_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = ST_INS_RD;
                end
            end

            ST_REL_RD:
            begin
                if (idx_reg < cnt_reg && int'(idx_reg) < MAX_RUN)
                begin
                    ram_raddr  = ring_addr(head_reg, idx_reg);
                    state_next = ST_REL_CHK;
                end
                else
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_EMIT_RD;
            end

            ST_REL_CHK:
            begin
                if (due)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_REL_RD;
                end
                else
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                ram_raddr  = head_reg;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                out_next   = ram_rdata;
                rk_next    = RK_RELEASE;
                last_next  = (idx_reg == CNT_W'(1));
                pop_next   = 1'b1;
                state_next = ST_OUT_WAIT;
            end

            ST_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    if (pop_reg)
                    begin
                        head_next  = ring_addr(head_reg, CNT_W'(1));
                        cnt_next   = cnt_reg - CNT_W'(1);
                        idx_next   = idx_reg - CNT_W'(1);
                        state_next = (idx_reg == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid    = (state_reg == ST_OUT_WAIT);
    assign result_kind  = rk_reg;
    assign out_kind     = out_reg.kind;
    assign out_x        = out_reg.x;
    assign out_y        = out_reg.y;
    assign out_z        = out_reg.z;
    assign out_facing   = out_reg.facing;
    assign out_flags    = out_reg.flags;
    assign out_callback = out_reg.callback;
    assign last_of_run  = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_purge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_PURGE |=> cnt_reg == '0)
        else $error("purge left entries in the queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pop_reg |-> cnt_reg != '0 && idx_reg != '0)
        else $error("release from an empty queue");

endmodule
